// File: hdl/cnls_pkg.sv
// Shared types and constants for the character LCD nibble sequencer.
package cnls_pkg;

    localparam int MAX_STROBES = 12;
    localparam int CNT_W       = $clog2(MAX_STROBES + 1);
    localparam int IDX_W       = $clog2(MAX_STROBES);

    typedef enum logic [1:0] {
        REQ_CMD  = 2'd0,
        REQ_DATA = 2'd1,
        REQ_PUTC = 2'd2,
        REQ_NONE = 2'd3
    } req_code_t;

    localparam logic [3:0] FUNC_SET_HI = 4'h2;

    typedef struct packed {
        logic       rs;
        logic       rw;
        logic [3:0] nib;
    } strobe_t;

    localparam strobe_t STROBE_STATUS = '{rs: 1'b0, rw: 1'b1, nib: 4'h0};

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       cmd_poll;
        logic [3:0] column;
        logic       row;
        logic       busy_first;
        logic       busy_second;
    } req_t;

    typedef struct packed {
        strobe_t [MAX_STROBES-1:0] list;
        logic [CNT_W-1:0]          count;
    } plan_t;

endpackage

// File: hdl/cnls_if.sv
// Request and strobe channel interfaces.
interface cnls_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       cmd_poll;
    logic [3:0] column;
    logic       row;
    logic       busy_first;
    logic       busy_second;

    modport source (output valid, req_type, data_byte, cmd_poll, column, row,
                    busy_first, busy_second, input ready);
    modport sink   (input valid, req_type, data_byte, cmd_poll, column, row,
                    busy_first, busy_second, output ready);
endinterface

interface cnls_strobe_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic       read_write;
    logic [3:0] nibble;
    logic       last;

    modport source (output valid, reg_select, read_write, nibble, last, input ready);
    modport sink   (input valid, reg_select, read_write, nibble, last, output ready);
endinterface

// File: hdl/cnls_decode.sv
// Expands one request into its ordered list of E-strobes.
module cnls_decode
    import cnls_pkg::*;
(
    input  req_t  req,
    input  logic  width_set_seen,
    output plan_t plan,
    output logic  set_width
);

    logic [IDX_W:0] idx;
    logic [7:0]     addr;
    strobe_t [MAX_STROBES-1:0] list;

    assign addr = {1'b1, req.row, 2'b00, req.column};

    always_comb
    begin
        list      = '0;
        idx       = '0;
        set_width = 1'b0;
        unique case (req_code_t'(req.req_type))
            REQ_CMD:
            begin
                if (req.cmd_poll)
                begin
                    list[idx[IDX_W-1:0]] = STROBE_STATUS; idx = idx + 1'b1;
                    list[idx[IDX_W-1:0]] = STROBE_STATUS; idx = idx + 1'b1;
                    if (req.busy_first)
                    begin
                        list[idx[IDX_W-1:0]] = STROBE_STATUS; idx = idx + 1'b1;
                        list[idx[IDX_W-1:0]] = STROBE_STATUS; idx = idx + 1'b1;
                    end
                end
                list[idx[IDX_W-1:0]] = '{1'b0, 1'b0, req.data_byte[7:4]};
                idx = idx + 1'b1;
                // first function set: strobe the high nibble twice to switch width
                if (!width_set_seen && req.data_byte[7:4] == FUNC_SET_HI)
                begin
                    set_width = 1'b1;
                    list[idx[IDX_W-1:0]] = '{1'b0, 1'b0, req.data_byte[7:4]};
                    idx = idx + 1'b1;
                end
                list[idx[IDX_W-1:0]] = '{1'b0, 1'b0, req.data_byte[3:0]};
                idx = idx + 1'b1;
            end
            REQ_DATA:
            begin
                list[idx[IDX_W-1:0]] = STROBE_STATUS; idx = idx + 1'b1;
                list[idx[IDX_W-1:0]] = STROBE_STATUS; idx = idx + 1'b1;
                if (req.busy_first)
                begin
                    list[idx[IDX_W-1:0]] = STROBE_STATUS; idx = idx + 1'b1;
                    list[idx[IDX_W-1:0]] = STROBE_STATUS; idx = idx + 1'b1;
                end
                list[idx[IDX_W-1:0]] = '{1'b1, 1'b0, req.data_byte[7:4]};
                idx = idx + 1'b1;
                list[idx[IDX_W-1:0]] = '{1'b1, 1'b0, req.data_byte[3:0]};
                idx = idx + 1'b1;
            end
            REQ_PUTC:
            begin
                list[idx[IDX_W-1:0]] = STROBE_STATUS; idx = idx + 1'b1;
                list[idx[IDX_W-1:0]] = STROBE_STATUS; idx = idx + 1'b1;
                if (req.busy_first)
                begin
                    list[idx[IDX_W-1:0]] = STROBE_STATUS; idx = idx + 1'b1;
                    list[idx[IDX_W-1:0]] = STROBE_STATUS; idx = idx + 1'b1;
                end
                // address high nibble is 8 or C, so never doubled
                list[idx[IDX_W-1:0]] = '{1'b0, 1'b0, addr[7:4]}; idx = idx + 1'b1;
                list[idx[IDX_W-1:0]] = '{1'b0, 1'b0, addr[3:0]}; idx = idx + 1'b1;
                list[idx[IDX_W-1:0]] = STROBE_STATUS; idx = idx + 1'b1;
                list[idx[IDX_W-1:0]] = STROBE_STATUS; idx = idx + 1'b1;
                if (req.busy_second)
                begin
                    list[idx[IDX_W-1:0]] = STROBE_STATUS; idx = idx + 1'b1;
                    list[idx[IDX_W-1:0]] = STROBE_STATUS; idx = idx + 1'b1;
                end
                list[idx[IDX_W-1:0]] = '{1'b1, 1'b0, req.data_byte[7:4]};
                idx = idx + 1'b1;
                list[idx[IDX_W-1:0]] = '{1'b1, 1'b0, req.data_byte[3:0]};
                idx = idx + 1'b1;
            end
            REQ_NONE:
            begin
                idx = '0;
            end
            default:
            begin
                idx = '0;
            end
        endcase
        plan.list  = list;
        plan.count = CNT_W'(idx);
    end

endmodule

// File: hdl/char_lcd_nibble_sequencer.sv
// Top level: plan register, strobe plan walker and strobe output register.
// A request's plan is registered on acceptance; its first strobe then enters the output register when it is free.
// Throughput: one strobe per cycle while the strobe side is ready, 2 to 12 strobes per request;
//   the next request is taken in the cycle the final strobe enters the output register.
// An unknown request type is taken and gives no strobes.
// Reset: rst_n asynchronous, clears the plan valid and position, the output valid and the width-set flag.
module char_lcd_nibble_sequencer
    import cnls_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cnls_req_if.sink             req,
    cnls_strobe_if.source        strobe
);

    req_t                      req_in;
    plan_t                     plan;
    logic                      set_width;

    strobe_t [MAX_STROBES-1:0] list_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [IDX_W-1:0]          pos_reg,  pos_next;
    logic                      plan_valid_reg, plan_valid_next;
    logic                      width_set_reg,  width_set_next;

    strobe_t                   out_reg;
    logic                      out_last_reg;
    logic                      out_valid_reg, out_valid_next;

    logic                      accept;
    logic                      emit;
    logic                      pos_final;
    logic                      plan_done;

    assign req_in = '{req_type:    req.req_type,
                      data_byte:   req.data_byte,
                      cmd_poll:    req.cmd_poll,
                      column:      req.column,
                      row:         req.row,
                      busy_first:  req.busy_first,
                      busy_second: req.busy_second};

    cnls_decode u_decode (
        .req            (req_in),
        .width_set_seen (width_set_reg),
        .plan           (plan),
        .set_width      (set_width)
    );

    assign emit      = plan_valid_reg && (!out_valid_reg || strobe.ready);
    assign pos_final = (CNT_W'(pos_reg) == count_reg - CNT_W'(1));
    assign plan_done = emit && pos_final;
    assign req.ready = !plan_valid_reg || plan_done;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        plan_valid_next = plan_valid_reg;
        pos_next        = pos_reg;
        width_set_next  = width_set_reg;
        if (plan_done)
        begin
            plan_valid_next = 1'b0;
        end
        else if (emit)
        begin
            pos_next = pos_reg + 1'b1;
        end
        if (accept)
        begin
            plan_valid_next = (plan.count != '0);
            pos_next        = '0;
            width_set_next  = width_set_reg | set_width;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (strobe.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plan_valid_reg <= 1'b0;
            pos_reg        <= '0;
            width_set_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            plan_valid_reg <= plan_valid_next;
            pos_reg        <= pos_next;
            width_set_reg  <= width_set_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            list_reg  <= plan.list;
            count_reg <= plan.count;
        end
        if (emit)
        begin
            out_reg      <= list_reg[pos_reg];
            out_last_reg <= pos_final;
        end
    end

    assign strobe.valid      = out_valid_reg;
    assign strobe.reg_select = out_reg.rs;
    assign strobe.read_write = out_reg.rw;
    assign strobe.nibble     = out_reg.nib;
    assign strobe.last       = out_last_reg;

endmodule

// File: hdl/cnls_checker.sv
// Port-level checks on the sequencer, bound to the top level.
module cnls_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       reg_select,
    input logic       read_write,
    input logic [3:0] nibble,
    input logic       last
);

    // a stalled strobe holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({reg_select, read_write, nibble, last}))
        else $error("strobe changed while stalled");

    // strobes of one request follow without gaps
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("gap inside a request's strobes");

    // status reads drive RS low and no nibble
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_write |-> !reg_select && nibble == 4'h0 && !last)
        else $error("malformed status read strobe");

    // a strobe that starts after an idle output is never a data read
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && $past(rst_n) |-> !reg_select || !read_write)
        else $error("data strobe with read level");

endmodule

bind char_lcd_nibble_sequencer cnls_checker u_cnls_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (strobe.valid),
    .out_ready  (strobe.ready),
    .reg_select (strobe.reg_select),
    .read_write (strobe.read_write),
    .nibble     (strobe.nibble),
    .last       (strobe.last)
);

// File: bench/char_lcd_nibble_sequencer_tb.sv
// Self-checking testbench for the character LCD nibble sequencer.
`timescale 1ns / 100ps

module char_lcd_nibble_sequencer_tb;
    import cnls_pkg::*;

    localparam logic [7:0] SET_DDRAM_ADDR = 8'h80;
    localparam logic [7:0] ROW1_OFFSET    = 8'h40;
    localparam int         RANDOM_REQS    = 225;
    localparam int         HOLD_OFF_START = 80;
    localparam int         HOLD_OFF_LEN   = 300;
    localparam int         REQ_W          = $bits(req_t);

    typedef struct packed {
        strobe_t pin;
        logic    last;
    } lcd_strobe_t;

    typedef struct {
        req_t        body;
        int unsigned gap;
        bit          drain;
    } pending_req_t;

    logic clk;
    logic rst_n;

    cnls_req_if    req_ch ();
    cnls_strobe_if strobe_ch ();

    char_lcd_nibble_sequencer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_ch),
        .strobe (strobe_ch)
    );

    pending_req_t pending_q[$];
    lcd_strobe_t  strobe_q[$];

    logic         width_set_done;
    req_t         cur_req;
    pending_req_t head;
    int           predicted_total;
    int           accepted_reqs;
    int           strobes_seen;
    int           err_count;
    int unsigned  stall_left;
    int unsigned  next_stall;
    logic         hold_off;
    lcd_strobe_t  want;

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned pick_pause();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 50);
    endfunction

    function automatic strobe_t write_strobe(logic rs, logic [3:0] nib);
        return strobe_t'{rs: rs, rw: 1'b0, nib: nib};
    endfunction

    function automatic void push_strobe(strobe_t s);
        lcd_strobe_t e;
        e.pin  = s;
        e.last = 1'b0;
        strobe_q.push_back(e);
    endfunction

    // One poll is two status reads; a busy poll is repeated once only.
    function automatic void poll_busy(logic busy);
        push_strobe(STROBE_STATUS);
        push_strobe(STROBE_STATUS);
        if (busy)
        begin
            push_strobe(STROBE_STATUS);
            push_strobe(STROBE_STATUS);
        end
    endfunction

    function automatic void send_cmd(logic [7:0] value);
        push_strobe(write_strobe(1'b0, value[7:4]));
        // The first function set repeats its high nibble to switch the bus width.
        if (!width_set_done && value[7:4] == FUNC_SET_HI)
        begin
            width_set_done = 1'b1;
            push_strobe(write_strobe(1'b0, value[7:4]));
        end
        push_strobe(write_strobe(1'b0, value[3:0]));
    endfunction

    function automatic void send_char(logic [7:0] value);
        push_strobe(write_strobe(1'b1, value[7:4]));
        push_strobe(write_strobe(1'b1, value[3:0]));
    endfunction

    function automatic int plan_strobes(req_t r);
        int          start;
        lcd_strobe_t tail;
        start = strobe_q.size();
        case (r.req_type)
            REQ_CMD:
            begin
                if (r.cmd_poll)
                    poll_busy(r.busy_first);
                send_cmd(r.data_byte);
            end
            REQ_DATA:
            begin
                poll_busy(r.busy_first);
                send_char(r.data_byte);
            end
            REQ_PUTC:
            begin
                poll_busy(r.busy_first);
                send_cmd(SET_DDRAM_ADDR | (r.row ? ROW1_OFFSET : 8'h00) | {4'h0, r.column});
                poll_busy(r.busy_second);
                send_char(r.data_byte);
            end
            default:
            begin
            end
        endcase
        if (strobe_q.size() > start)
        begin
            tail = strobe_q[strobe_q.size() - 1];
            tail.last = 1'b1;
            strobe_q[strobe_q.size() - 1] = tail;
        end
        return strobe_q.size() - start;
    endfunction

    function automatic req_t make_req(req_code_t kind, logic [7:0] value, logic wchk,
                                      logic [3:0] col, logic row_sel, logic b1, logic b2);
        req_t r;
        r.req_type    = kind;
        r.data_byte   = value;
        r.cmd_poll    = wchk;
        r.column      = col;
        r.row         = row_sel;
        r.busy_first  = b1;
        r.busy_second = b2;
        return r;
    endfunction

    function automatic void queue_req(req_t r, int unsigned gap, bit drain);
        pending_req_t p;
        p.body  = r;
        p.gap   = gap;
        p.drain = drain;
        pending_q.push_back(p);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_CMD;
        req_ch.data_byte   = 8'h00;
        req_ch.cmd_poll    = 1'b0;
        req_ch.column      = 4'h0;
        req_ch.row         = 1'b0;
        req_ch.busy_first  = 1'b0;
        req_ch.busy_second = 1'b0;
        strobe_ch.ready    = 1'b0;
        hold_off           = 1'b0;
        rst_n              = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            width_set_done  = 1'b0;
            predicted_total = 0;
            accepted_reqs   = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predicted_total += plan_strobes(cur_req);
                accepted_reqs++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_q.size() == 0)
                    req_ch.valid <= 1'b0;
                else if (pending_q[0].gap != 0)
                begin
                    head = pending_q[0];
                    head.gap--;
                    pending_q[0] = head;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_q[0].drain && predicted_total != strobes_seen)
                    req_ch.valid <= 1'b0;
                else
                begin
                    head    = pending_q.pop_front();
                    cur_req = head.body;
                    req_ch.req_type    <= head.body.req_type;
                    req_ch.data_byte   <= head.body.data_byte;
                    req_ch.cmd_poll    <= head.body.cmd_poll;
                    req_ch.column      <= head.body.column;
                    req_ch.row         <= head.body.row;
                    req_ch.busy_first  <= head.body.busy_first;
                    req_ch.busy_second <= head.body.busy_second;
                    req_ch.valid       <= 1'b1;
                end
            end
        end
    end

    // Strobe monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_ch.ready <= 1'b0;
            strobes_seen    <= 0;
            err_count       = 0;
            stall_left      = 0;
        end
        else
        begin
            if (strobe_ch.valid && strobe_ch.ready)
            begin
                strobes_seen <= strobes_seen + 1;
                if (strobe_q.size() == 0)
                begin
                    $error("unexpected strobe: rs %0b rw %0b nibble %h last %0b",
                           strobe_ch.reg_select, strobe_ch.read_write,
                           strobe_ch.nibble, strobe_ch.last);
                    err_count++;
                end
                else
                begin
                    want = strobe_q.pop_front();
                    if (strobe_ch.reg_select !== want.pin.rs)
                    begin
                        $error("reg_select: expected %0b, got %0b",
                               want.pin.rs, strobe_ch.reg_select);
                        err_count++;
                    end
                    if (strobe_ch.read_write !== want.pin.rw)
                    begin
                        $error("read_write: expected %0b, got %0b",
                               want.pin.rw, strobe_ch.read_write);
                        err_count++;
                    end
                    if (strobe_ch.nibble !== want.pin.nib)
                    begin
                        $error("nibble: expected %h, got %h", want.pin.nib, strobe_ch.nibble);
                        err_count++;
                    end
                    if (strobe_ch.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, strobe_ch.last);
                        err_count++;
                    end
                end
            end
            // Take every strobe without a stall in one window out of four.
            if (hold_off)
                strobe_ch.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                strobe_ch.ready <= 1'b0;
            end
            else
            begin
                next_stall = ((strobes_seen / 128) % 4 == 1) ? 0 : pick_pause();
                if (next_stall > 0)
                begin
                    stall_left = next_stall - 1;
                    strobe_ch.ready <= 1'b0;
                end
                else
                    strobe_ch.ready <= 1'b1;
            end
        end
    end

    // Hold the strobe side off while requests keep coming, so the input backs up.
    initial
    begin
        @(posedge rst_n);
        while (accepted_reqs < HOLD_OFF_START)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("char_lcd_nibble_sequencer_tb: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        req_t r;
        int   counted;
        int   idx;

        // Commands before and at the first function set, then one that is not doubled.
        queue_req(make_req(REQ_CMD,  8'h01, 1'b0, 4'h0, 1'b0, 1'b1, 1'b1), 0, 1'b0);
        queue_req(make_req(REQ_PUTC, 8'h41, 1'b0, 4'h2, 1'b0, 1'b0, 1'b0), pick_pause(), 1'b0);
        queue_req(make_req(REQ_CMD,  8'h28, 1'b1, 4'h0, 1'b0, 1'b1, 1'b0), pick_pause(), 1'b0);
        queue_req(make_req(REQ_CMD,  8'h2C, 1'b0, 4'hF, 1'b1, 1'b0, 1'b1), pick_pause(), 1'b0);
        queue_req(make_req(REQ_CMD,  8'h20, 1'b1, 4'h0, 1'b0, 1'b0, 1'b0), pick_pause(), 1'b0);
        queue_req(make_req(REQ_CMD,  8'hFF, 1'b1, 4'hF, 1'b1, 1'b0, 1'b1), pick_pause(), 1'b0);
        queue_req(make_req(REQ_CMD,  8'h00, 1'b0, 4'h0, 1'b0, 1'b1, 1'b0), pick_pause(), 1'b0);
        queue_req(make_req(REQ_DATA, 8'h00, 1'b0, 4'h0, 1'b0, 1'b0, 1'b0), pick_pause(), 1'b0);
        queue_req(make_req(REQ_DATA, 8'hFF, 1'b1, 4'hF, 1'b1, 1'b1, 1'b1), pick_pause(), 1'b0);
        queue_req(make_req(REQ_DATA, 8'h5A, 1'b0, 4'h9, 1'b0, 1'b0, 1'b1), pick_pause(), 1'b0);
        queue_req(make_req(REQ_PUTC, 8'h00, 1'b0, 4'h0, 1'b0, 1'b0, 1'b0), pick_pause(), 1'b0);
        queue_req(make_req(REQ_PUTC, 8'hFF, 1'b1, 4'hF, 1'b1, 1'b1, 1'b1), pick_pause(), 1'b0);
        queue_req(make_req(REQ_PUTC, 8'hA5, 1'b0, 4'h7, 1'b1, 1'b0, 1'b1), pick_pause(), 1'b0);
        queue_req(make_req(REQ_PUTC, 8'h5A, 1'b1, 4'h8, 1'b0, 1'b1, 1'b0), pick_pause(), 1'b0);
        // Unknown request type: swallowed with no strobes.
        queue_req(make_req(REQ_NONE, 8'hFF, 1'b1, 4'hF, 1'b1, 1'b1, 1'b1), pick_pause(), 1'b0);
        queue_req(make_req(REQ_NONE, 8'h00, 1'b0, 4'h0, 1'b0, 1'b0, 1'b0), 0, 1'b0);
        queue_req(make_req(REQ_CMD,  8'h2A, 1'b1, 4'h3, 1'b0, 1'b0, 1'b1), 0, 1'b0);
        queue_req(make_req(REQ_CMD,  8'h0C, 1'b0, 4'hC, 1'b1, 1'b1, 1'b1), pick_pause(), 1'b0);

        counted = 0;
        idx     = 0;
        while (counted < RANDOM_REQS)
        begin
            r = req_t'(REQ_W'($urandom));
            if (r.req_type == REQ_NONE && $urandom_range(0, 9) != 0)
                r.req_type = 2'($urandom_range(0, 2));
            if (r.req_type != REQ_NONE)
                counted++;
            // Back-to-back stretch in the middle; drain the pipe now and then.
            queue_req(r, (counted >= 120 && counted < 160) ? 0 : pick_pause(),
                      idx == 0 || $urandom_range(0, 49) == 0);
            idx++;
        end

        @(posedge rst_n);
        while (pending_q.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (predicted_total != strobes_seen)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (err_count == 0 && strobe_q.size() == 0)
            $display("char_lcd_nibble_sequencer_tb: done, clean");
        else
            $display("char_lcd_nibble_sequencer_tb: done, errors");
        $finish;
    end

endmodule
